[rtl/smfr_pkg.sv]
// Shared types, constants and saturation helper for the stereo multitap reverb.
`timescale 1ns / 1ps

package smfr_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int TAP_W       = 17;
  localparam int FB_W        = 16;
  localparam int GAIN_W      = 17;
  localparam int FBP_W       = 32;
  localparam int NUM_TAPS    = 4;
  localparam int NUM_REGS    = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 17;
  localparam int SAT_W       = SAMPLE_BITS + 3;

  localparam logic [GAIN_W-1:0] GAIN_ONE     = GAIN_W'(65536);
  localparam logic [FB_W-1:0]   FEEDBACK_MAX = FB_W'(62259);

  localparam int TAP_RESET [NUM_TAPS] = '{1392, 2064, 3408, 5424};

  localparam logic [CFG_IDX_W-1:0] REG_TAP_DELAY_1  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_DELAY_2  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_DELAY_3  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TAP_DELAY_4  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FEEDBACK     = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_WET          = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_DAMPING      = 3'd6;

  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MAX = {1'b0, {(SAMPLE_BITS-1){1'b1}}};
  localparam logic signed [SAMPLE_BITS-1:0] SAMPLE_MIN = {1'b1, {(SAMPLE_BITS-1){1'b0}}};

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_in;
    logic signed [SAMPLE_BITS-1:0] right_in;
    logic                          block_end;
  } in_item_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
    logic                          block_end_out;
  } out_item_t;

  // Per-cycle strobes from the sequencer to both lanes
  typedef struct packed {
    logic load;
    logic rd_en;
    logic rd_live;
    logic acc_en;
    logic acc_first;
    logic mul_en;
    logic wr_en;
  } lane_ctrl_t;

  // Clamped gains shared by the lanes
  typedef struct packed {
    logic [FBP_W-1:0]  fb_prod;
    logic [GAIN_W-1:0] wet;
    logic [GAIN_W-1:0] dry;
  } gain_t;

  function automatic logic signed [SAMPLE_BITS-1:0] sat_sample(
    input logic signed [SAT_W-1:0] v
  );
    logic signed [SAT_W-1:0] hi;
    logic signed [SAT_W-1:0] lo;
    hi = SAT_W'(SAMPLE_MAX);
    lo = SAT_W'(SAMPLE_MIN);
    if (v > hi) begin
      return SAMPLE_MAX;
    end else if (v < lo) begin
      return SAMPLE_MIN;
    end else begin
      return v[SAMPLE_BITS-1:0];
    end
  endfunction

endpackage

[rtl/smfr_lane.sv]
// One channel lane: delay store, tap accumulator, feedback and mix arithmetic.
`timescale 1ns / 1ps

module smfr_lane #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                                    clk,
  input  logic signed [smfr_pkg::SAMPLE_BITS-1:0] in_sample,
  input  smfr_pkg::lane_ctrl_t                    ctl,
  input  logic [$clog2(DELAY_DEPTH)-1:0]          mem_addr,
  input  smfr_pkg::gain_t                         gains,
  output logic signed [smfr_pkg::SAMPLE_BITS-1:0] out_sample
);
  import smfr_pkg::*;

  localparam int SB    = SAMPLE_BITS;
  localparam int SUMW  = SB + 2;
  localparam int DRYW  = SB + GAIN_W + 1;
  localparam int FBPW  = SB + FBP_W + 1;
  localparam int MIXW  = DRYW + 1;

  logic signed [SB-1:0]   mem [DELAY_DEPTH];
  logic signed [SB-1:0]   rd_q_r;
  logic                   live_r;
  logic signed [SB-1:0]   tap;
  logic signed [SUMW-1:0] sum_r;
  logic signed [SB-1:0]   sample_r;
  logic signed [SB-1:0]   avg;
  logic signed [DRYW-1:0] dry_r;
  logic signed [DRYW-1:0] wetp_r;
  logic signed [FBPW-1:0] fbp_r;
  logic signed [SB:0]     fb_term;
  logic signed [SB+1:0]   wr_sum;
  logic signed [SB-1:0]   wr_data;
  logic signed [MIXW-1:0] mix;

  // Single port: a write and a read never fall in the same cycle
  always_ff @(posedge clk) begin
    if (ctl.wr_en) begin
      mem[mem_addr] <= wr_data;
    end else if (ctl.rd_en) begin
      rd_q_r <= mem[mem_addr];
    end
  end

  // Entries not yet reached by the write pointer read as zero
  assign tap = live_r ? rd_q_r : '0;
  assign avg = sum_r[SUMW-1:2];

  always_ff @(posedge clk) begin
    if (ctl.rd_en) begin
      live_r <= ctl.rd_live;
    end
    if (ctl.load) begin
      sample_r <= in_sample;
    end
    if (ctl.acc_en) begin
      sum_r <= ctl.acc_first ? SUMW'(tap) : sum_r + SUMW'(tap);
    end
    dry_r <= sample_r * $signed({1'b0, gains.dry});
    if (ctl.mul_en) begin
      fbp_r  <= avg * $signed({1'b0, gains.fb_prod});
      wetp_r <= avg * $signed({1'b0, gains.wet});
    end
  end

  assign fb_term    = fbp_r[FBPW-1:FBP_W];
  assign wr_sum     = (SB+2)'(sample_r) + (SB+2)'(fb_term);
  assign wr_data    = sat_sample(SAT_W'(wr_sum));
  assign mix        = MIXW'(dry_r) + MIXW'(wetp_r);
  assign out_sample = sat_sample(mix[MIXW-1:16]);

endmodule

[rtl/smfr_seq.sv]
// Sequencer: configuration registers, write pointer, tap addressing and item control.
`timescale 1ns / 1ps

module smfr_seq #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_stall,
  input  logic                               in_block_end,
  input  logic                               cfg_we,
  input  logic [smfr_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [smfr_pkg::CFG_DATA_W-1:0]    cfg_data,
  input  logic                               slot_free,
  output smfr_pkg::lane_ctrl_t               ctl,
  output logic [$clog2(DELAY_DEPTH)-1:0]     mem_addr,
  output smfr_pkg::gain_t                    gains,
  output logic                               done,
  output logic                               block_end_q
);
  import smfr_pkg::*;

  localparam int AW        = $clog2(DELAY_DEPTH);
  localparam int RED_STEPS = (DELAY_DEPTH >= (1 << TAP_W)) ? 1 :
                             $clog2(((1 << TAP_W) + DELAY_DEPTH - 1) / DELAY_DEPTH) + 1;
  localparam int RW        = AW + RED_STEPS;

  typedef enum logic [2:0] {
    S_IDLE,
    S_RD,
    S_ACC,
    S_MUL,
    S_WR
  } state_t;

  state_t            state_r, state_nxt;
  logic              ready_r;
  logic [1:0]        cnt_r, cnt_nxt;
  logic [AW-1:0]     wp_r, wp_nxt;
  logic              wrapped_r, wrapped_nxt;
  logic              be_r;
  logic [AW-1:0]     tap_r [NUM_TAPS];
  logic [FB_W-1:0]   fb_r;
  logic [GAIN_W-1:0] wet_r;
  logic [GAIN_W-1:0] damp_r;
  gain_t             gains_r;
  logic [RW-1:0]     red_v;
  logic [AW-1:0]     cfg_dist;
  logic [1:0]        tap_sel;
  logic [AW-1:0]     tap_d;
  logic [AW:0]       diff;
  logic [AW-1:0]     tap_addr;
  logic              accept;
  logic [FB_W-1:0]   fb_c;
  logic [GAIN_W-1:0] wet_c;
  logic [GAIN_W-1:0] keep_c;

  assign accept   = in_valid && ready_r;
  assign in_stall = !ready_r;

  // Reduce a written tap distance modulo the store depth by shifted compare-subtract
  always_comb begin
    red_v = RW'(cfg_data[TAP_W-1:0]);
    for (int k = RED_STEPS - 1; k >= 0; k--) begin
      if (red_v >= (RW'(DELAY_DEPTH) << k)) begin
        red_v = red_v - (RW'(DELAY_DEPTH) << k);
      end
    end
  end
  assign cfg_dist = red_v[AW-1:0];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int k = 0; k < NUM_TAPS; k++) begin
        tap_r[k] <= AW'(TAP_RESET[k] % DELAY_DEPTH);
      end
      fb_r   <= '0;
      wet_r  <= '0;
      damp_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_TAP_DELAY_1: tap_r[0] <= cfg_dist;
        REG_TAP_DELAY_2: tap_r[1] <= cfg_dist;
        REG_TAP_DELAY_3: tap_r[2] <= cfg_dist;
        REG_TAP_DELAY_4: tap_r[3] <= cfg_dist;
        REG_FEEDBACK:    fb_r     <= cfg_data[FB_W-1:0];
        REG_WET:         wet_r    <= cfg_data[GAIN_W-1:0];
        REG_DAMPING:     damp_r   <= cfg_data[GAIN_W-1:0];
        default: ;
      endcase
    end
  end

  assign fb_c   = (fb_r > FEEDBACK_MAX) ? FEEDBACK_MAX : fb_r;
  assign wet_c  = (wet_r > GAIN_ONE) ? GAIN_ONE : wet_r;
  assign keep_c = GAIN_ONE - ((damp_r > GAIN_ONE) ? GAIN_ONE : damp_r);

  // Fold damping into feedback once so each lane needs a single multiply
  always_ff @(posedge clk) begin
    gains_r.fb_prod <= FBP_W'(keep_c) * FBP_W'(fb_c);
    gains_r.wet     <= wet_c;
    gains_r.dry     <= GAIN_ONE - wet_c;
  end
  assign gains = gains_r;

  // Tap address behind the write pointer, wrapped into the store
  assign tap_sel  = (state_r == S_IDLE) ? 2'd0 : cnt_r;
  assign tap_d    = tap_r[tap_sel];
  assign diff     = {1'b0, wp_r} - {1'b0, tap_d};
  assign tap_addr = diff[AW] ? AW'(diff + (AW+1)'(DELAY_DEPTH)) : diff[AW-1:0];
  assign mem_addr = (state_r == S_WR) ? wp_r : tap_addr;

  always_comb begin
    state_nxt   = state_r;
    cnt_nxt     = cnt_r;
    wp_nxt      = wp_r;
    wrapped_nxt = wrapped_r;
    ctl         = '0;
    done        = 1'b0;
    case (state_r)
      S_IDLE: begin
        if (accept) begin
          ctl.load  = 1'b1;
          ctl.rd_en = 1'b1;
          cnt_nxt   = 2'd1;
          state_nxt = S_RD;
        end
      end
      S_RD: begin
        ctl.rd_en     = 1'b1;
        ctl.acc_en    = 1'b1;
        ctl.acc_first = (cnt_r == 2'd1);
        if (cnt_r == 2'd3) begin
          state_nxt = S_ACC;
        end else begin
          cnt_nxt = cnt_r + 2'd1;
        end
      end
      S_ACC: begin
        ctl.acc_en = 1'b1;
        state_nxt  = S_MUL;
      end
      S_MUL: begin
        ctl.mul_en = 1'b1;
        state_nxt  = S_WR;
      end
      S_WR: begin
        // Hold until the output register can take the item
        if (slot_free) begin
          ctl.wr_en = 1'b1;
          done      = 1'b1;
          state_nxt = S_IDLE;
          if (wp_r == AW'(DELAY_DEPTH - 1)) begin
            wp_nxt      = '0;
            wrapped_nxt = 1'b1;
          end else begin
            wp_nxt = wp_r + AW'(1);
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
    ctl.rd_live = wrapped_r || (tap_addr < wp_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_IDLE;
      ready_r   <= 1'b0;
      cnt_r     <= '0;
      wp_r      <= '0;
      wrapped_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      ready_r   <= (state_nxt == S_IDLE);
      cnt_r     <= cnt_nxt;
      wp_r      <= wp_nxt;
      wrapped_r <= wrapped_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      be_r <= in_block_end;
    end
  end
  assign block_end_q = be_r;

endmodule

[rtl/smfr_merge.sv]
// Merge stage: joins both lanes' results into one output item and holds it.
`timescale 1ns / 1ps

module smfr_merge (
  input  logic                                    clk,
  input  logic                                    rst_n,
  input  logic                                    done,
  input  logic signed [smfr_pkg::SAMPLE_BITS-1:0] left_res,
  input  logic signed [smfr_pkg::SAMPLE_BITS-1:0] right_res,
  input  logic                                    block_end_q,
  output logic                                    slot_free,
  output logic                                    out_valid,
  input  logic                                    out_stall,
  output smfr_pkg::out_item_t                     out_data
);
  import smfr_pkg::*;

  logic      out_valid_r;
  out_item_t out_data_r;

  assign slot_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (done) begin
      out_valid_r <= 1'b1;
    end else if (!out_stall) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (done) begin
      out_data_r.left_out      <= left_res;
      out_data_r.right_out     <= right_res;
      out_data_r.block_end_out <= block_end_q;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

[rtl/stereo_multitap_feedback_reverb_unit.sv]
// Each item runs through four tap reads, the last accumulate, the multiply stage and one
//   write-back on the single-port delay store per lane; no new item is taken until the
//   current one is written back.
// A waiting result in the output register does not block the next item until write-back.
// Reset (rst_n low, synchronous) restores register defaults, zeroes the write pointer;
//   store entries not yet written since reset read as zero, so no clearing pass is run.
`timescale 1ns / 1ps

module stereo_multitap_feedback_reverb_unit #(
  parameter int DELAY_DEPTH = 131072
) (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_stall,
  input  smfr_pkg::in_item_t              in_data,
  output logic                            out_valid,
  input  logic                            out_stall,
  output smfr_pkg::out_item_t             out_data,
  input  logic                            cfg_we,
  input  logic [smfr_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [smfr_pkg::CFG_DATA_W-1:0] cfg_data
);
  import smfr_pkg::*;

  localparam int AW = $clog2(DELAY_DEPTH);

  lane_ctrl_t                  ctl;
  gain_t                       gains;
  logic [AW-1:0]               mem_addr;
  logic                        done;
  logic                        block_end_q;
  logic                        slot_free;
  logic signed [SAMPLE_BITS-1:0] left_res;
  logic signed [SAMPLE_BITS-1:0] right_res;

  smfr_seq #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_seq (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_block_end (in_data.block_end),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data),
    .slot_free    (slot_free),
    .ctl          (ctl),
    .mem_addr     (mem_addr),
    .gains        (gains),
    .done         (done),
    .block_end_q  (block_end_q)
  );

  smfr_lane #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_lane_left (
    .clk        (clk),
    .in_sample  (in_data.left_in),
    .ctl        (ctl),
    .mem_addr   (mem_addr),
    .gains      (gains),
    .out_sample (left_res)
  );

  smfr_lane #(
    .DELAY_DEPTH (DELAY_DEPTH)
  ) u_lane_right (
    .clk        (clk),
    .in_sample  (in_data.right_in),
    .ctl        (ctl),
    .mem_addr   (mem_addr),
    .gains      (gains),
    .out_sample (right_res)
  );

  smfr_merge u_merge (
    .clk         (clk),
    .rst_n       (rst_n),
    .done        (done),
    .left_res    (left_res),
    .right_res   (right_res),
    .block_end_q (block_end_q),
    .slot_free   (slot_free),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .out_data    (out_data)
  );

endmodule

[rtl/smfr_checker.sv]
// Port-level checker for the reverb unit and its bind to the top level.
`timescale 1ns / 1ps

module smfr_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                in_valid,
  input logic                in_stall,
  input logic                out_valid,
  input logic                out_stall,
  input smfr_pkg::out_item_t out_data
);
  import smfr_pkg::*;

  logic [1:0] cnt_r, cnt_nxt;
  logic       in_acc;
  logic       out_acc;

  assign in_acc  = in_valid && !in_stall;
  assign out_acc = out_valid && !out_stall;

  // Track items accepted but not yet delivered
  always_comb begin
    cnt_nxt = cnt_r;
    if (in_acc && !out_acc) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (out_acc && !in_acc) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> (!out_valid && in_stall))
    else $error("outputs not quiet after reset");

  a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |=> in_stall)
    else $error("item accepted while another is in progress");

  a_no_invented: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (cnt_r != 2'd0))
    else $error("result shown without an outstanding item");

  a_bounded: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != 2'd3)
    else $error("more items outstanding than the unit can hold");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
    else $error("stalled result changed or dropped");

endmodule

bind stereo_multitap_feedback_reverb_unit smfr_checker u_smfr_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);

[sim/tb.sv]
// Self-checking testbench for the stereo multitap feedback reverb unit.
`timescale 1ns / 1ps

module tb;
  import smfr_pkg::*;

  localparam int DEPTH        = 131072;
  localparam int SETTLE       = 12;
  localparam int RANDOM_ITEMS = 1430;
  localparam int CYCLE_LIMIT  = 1000000;
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd7;

  typedef enum logic {ROW_CFG, ROW_ITEM} row_kind_t;

  typedef struct packed {
    row_kind_t             kind;
    logic [CFG_IDX_W-1:0]  idx;
    logic [CFG_DATA_W-1:0] val;
    in_item_t              stim;
    logic                  pinned;
    out_item_t             want;
  } row_t;

  typedef struct packed {
    logic      pinned;
    out_item_t want;
  } pin_t;

  logic                  clk       = 1'b0;
  logic                  rst_n     = 1'b0;
  logic                  in_valid  = 1'b0;
  logic                  in_stall;
  in_item_t              in_data   = '0;
  logic                  out_valid;
  logic                  out_stall = 1'b0;
  out_item_t             out_data;
  logic                  cfg_we    = 1'b0;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [CFG_DATA_W-1:0] cfg_data  = '0;

  // predictor state
  bit signed [SAMPLE_BITS-1:0] left_hist  [DEPTH];
  bit signed [SAMPLE_BITS-1:0] right_hist [DEPTH];
  logic [TAP_W-1:0]  head;
  logic [TAP_W-1:0]  tap_dist [NUM_TAPS];
  logic [FB_W-1:0]   fb_reg;
  logic [GAIN_W-1:0] wet_reg;
  logic [GAIN_W-1:0] damp_reg;

  out_item_t pending_mix_q [$];
  pin_t      pinned_mix_q [$];
  row_t      plan_q [$];

  int mismatch_count = 0;
  int cycle_count    = 0;
  int stall_run      = 0;
  bit calm           = 1'b0;
  bit settled        = 1'b1;

  always #1 clk = ~clk;

  stereo_multitap_feedback_reverb_unit dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_data  (out_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  function automatic logic signed [SAMPLE_BITS-1:0] clip(input longint v);
    if (v > longint'(SAMPLE_MAX)) return SAMPLE_MAX;
    if (v < longint'(SAMPLE_MIN)) return SAMPLE_MIN;
    return v[SAMPLE_BITS-1:0];
  endfunction

  // One channel: average the taps, write back input plus damped feedback, mix wet and dry
  function automatic logic signed [SAMPLE_BITS-1:0] lane_mix(
    input bit                          right,
    input logic signed [SAMPLE_BITS-1:0] dry_in
  );
    longint sum;
    longint avg;
    longint dry;
    longint fb;
    longint wet;
    longint keep;
    longint fb_term;
    logic [TAP_W-1:0] pos;
    int k;
    sum  = 0;
    dry  = dry_in;
    fb   = (fb_reg > FEEDBACK_MAX) ? FEEDBACK_MAX : fb_reg;
    wet  = (wet_reg > GAIN_ONE) ? GAIN_ONE : wet_reg;
    keep = (damp_reg > GAIN_ONE) ? GAIN_ONE : damp_reg;
    keep = longint'(GAIN_ONE) - keep;
    for (k = 0; k < NUM_TAPS; k++) begin
      pos = head - tap_dist[k];
      sum += right ? right_hist[pos] : left_hist[pos];
    end
    avg     = sum >>> 2;
    fb_term = (avg * keep * fb) >>> 32;
    if (right) begin
      right_hist[head] = clip(dry + fb_term);
    end else begin
      left_hist[head] = clip(dry + fb_term);
    end
    return clip((dry * (longint'(GAIN_ONE) - wet) + avg * wet) >>> 16);
  endfunction

  function automatic out_item_t reverb_sample(input in_item_t s);
    out_item_t r;
    r.left_out      = lane_mix(1'b0, s.left_in);
    r.right_out     = lane_mix(1'b1, s.right_in);
    r.block_end_out = s.block_end;
    head = head + 1'b1;
    return r;
  endfunction

  function automatic int pause_len();
    int r;
    r = $urandom_range(0, 99);
    if (r < 70) return $urandom_range(1, 2);
    if (r < 95) return $urandom_range(3, 6);
    return $urandom_range(7, 30);
  endfunction

  function automatic int gap_len();
    if ($urandom_range(0, 99) < 55) return 0;
    return pause_len();
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] rand_sample();
    case ($urandom_range(0, 7))
      0: return SAMPLE_MAX;
      1: return SAMPLE_MIN;
      2: return SAMPLE_BITS'($urandom_range(0, 512)) - SAMPLE_BITS'(256);
      default: return SAMPLE_BITS'($urandom());
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_tap();
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2: return CFG_DATA_W'($urandom_range(1, 131071));
      // short taps keep the feedback path busy within a phase
      default: return CFG_DATA_W'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_feedback();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(FEEDBACK_MAX);
      2: return '1;
      3: return CFG_DATA_W'($urandom());
      default: return CFG_DATA_W'($urandom_range(40000, 62259));
    endcase
  endfunction

  function automatic logic [CFG_DATA_W-1:0] pick_gain();
    case ($urandom_range(0, 5))
      0: return '0;
      1: return CFG_DATA_W'(GAIN_ONE);
      2: return '1;
      3: return CFG_DATA_W'($urandom());
      default: return CFG_DATA_W'($urandom_range(0, 65536));
    endcase
  endfunction

  function automatic void add_cfg(
    input logic [CFG_IDX_W-1:0]  idx,
    input logic [CFG_DATA_W-1:0] val
  );
    row_t r;
    r      = '0;
    r.kind = ROW_CFG;
    r.idx  = idx;
    r.val  = val;
    plan_q.push_back(r);
  endfunction

  function automatic void add_item(
    input logic signed [SAMPLE_BITS-1:0] l,
    input logic signed [SAMPLE_BITS-1:0] r_in,
    input logic                          be,
    input logic                          pinned,
    input logic signed [SAMPLE_BITS-1:0] wl,
    input logic signed [SAMPLE_BITS-1:0] wr
  );
    row_t r;
    r                    = '0;
    r.kind               = ROW_ITEM;
    r.stim.left_in       = l;
    r.stim.right_in      = r_in;
    r.stim.block_end     = be;
    r.pinned             = pinned;
    r.want.left_out      = wl;
    r.want.right_out     = wr;
    r.want.block_end_out = be;
    plan_q.push_back(r);
  endfunction

  task automatic settle_block();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_mix_q.size() != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    settled = 1'b1;
  endtask

  task automatic write_reg(
    input logic [CFG_IDX_W-1:0]  idx,
    input logic [CFG_DATA_W-1:0] val
  );
    if (!settled) settle_block();
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    @(posedge clk);
  endtask

  task automatic send_sample(
    input in_item_t  s,
    input logic      pinned,
    input out_item_t want
  );
    int gap;
    pin_t p;
    gap = calm ? 0 : gap_len();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    p.pinned = pinned;
    p.want   = want;
    pinned_mix_q.push_back(p);
    in_valid <= 1'b1;
    in_data  <= s;
    do @(posedge clk); while (in_stall);
    settled = 1'b0;
  endtask

  // Track config writes and accepted items; queue the expected mix for each item
  always @(posedge clk) begin : sample_track
    pin_t p;
    out_item_t got;
    int k;
    if (!rst_n) begin
      for (k = 0; k < NUM_TAPS; k++) tap_dist[k] = TAP_W'(TAP_RESET[k]);
      fb_reg   = '0;
      wet_reg  = '0;
      damp_reg = '0;
      head     = '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_TAP_DELAY_1: tap_dist[0] = cfg_data;
          REG_TAP_DELAY_2: tap_dist[1] = cfg_data;
          REG_TAP_DELAY_3: tap_dist[2] = cfg_data;
          REG_TAP_DELAY_4: tap_dist[3] = cfg_data;
          REG_FEEDBACK:    fb_reg      = cfg_data[FB_W-1:0];
          REG_WET:         wet_reg     = cfg_data;
          REG_DAMPING:     damp_reg    = cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        got = reverb_sample(in_data);
        p   = pinned_mix_q.pop_front();
        pending_mix_q.push_back(p.pinned ? p.want : got);
      end
    end
  end

  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_mix_q.size() == 0) begin
        $error("item with none expected: left_out=%0d right_out=%0d block_end_out=%0b",
               out_data.left_out, out_data.right_out, out_data.block_end_out);
        mismatch_count++;
      end else begin
        want = pending_mix_q.pop_front();
        if (out_data.left_out !== want.left_out) begin
          $error("left_out: expected %0d, got %0d", want.left_out, out_data.left_out);
          mismatch_count++;
        end
        if (out_data.right_out !== want.right_out) begin
          $error("right_out: expected %0d, got %0d", want.right_out, out_data.right_out);
          mismatch_count++;
        end
        if (out_data.block_end_out !== want.block_end_out) begin
          $error("block_end_out: expected %0b, got %0b",
                 want.block_end_out, out_data.block_end_out);
          mismatch_count++;
        end
      end
    end
  end

  // Hold off the result side in bursts; no new stall starts in calm phases
  always @(posedge clk) begin : stall_gen
    bit hold;
    if (stall_run != 0) begin
      stall_run <= stall_run - 1;
    end else begin
      hold = !calm && ($urandom_range(0, 2) == 0);
      out_stall <= hold;
      stall_run <= hold ? pause_len() : $urandom_range(0, 8);
    end
  end

  always @(posedge clk) begin : watchdog
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("stereo_multitap_feedback_reverb_unit: mismatch");
      $finish;
    end
  end

  initial begin : stimulus
    row_t row;
    in_item_t s;
    int n;
    int k;
    int len;
    // reset gains: fully dry, so the output is the input
    add_item(SAMPLE_MAX, SAMPLE_MAX, 1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MAX);
    add_item(SAMPLE_MIN, SAMPLE_MIN, 1'b0, 1'b1, SAMPLE_MIN, SAMPLE_MIN);
    add_item('0, -24'sd1, 1'b1, 1'b1, '0, -24'sd1);
    add_item(24'h555555, 24'hAAAAAA, 1'b0, 1'b1, 24'h555555, 24'hAAAAAA);
    // fully wet, taps behind anything written: silence
    add_cfg(REG_TAP_DELAY_1, 17'd100);
    add_cfg(REG_TAP_DELAY_2, 17'd200);
    add_cfg(REG_TAP_DELAY_3, 17'd300);
    add_cfg(REG_TAP_DELAY_4, 17'd400);
    add_cfg(REG_WET, CFG_DATA_W'(GAIN_ONE));
    add_cfg(REG_DAMPING, CFG_DATA_W'(GAIN_ONE));
    add_cfg(REG_FEEDBACK, '1);
    add_item(SAMPLE_MAX, SAMPLE_MIN, 1'b0, 1'b1, '0, '0);
    add_item(SAMPLE_MIN, SAMPLE_MAX, 1'b1, 1'b1, '0, '0);
    // zero and maximum tap distance, strongest feedback, half wet
    add_cfg(REG_TAP_DELAY_1, '0);
    add_cfg(REG_TAP_DELAY_2, 17'd1);
    add_cfg(REG_TAP_DELAY_3, 17'd2);
    add_cfg(REG_TAP_DELAY_4, '1);
    add_cfg(REG_WET, 17'd32768);
    add_cfg(REG_DAMPING, '0);
    add_cfg(REG_FEEDBACK, CFG_DATA_W'(FEEDBACK_MAX));
    add_item(SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0, '0, '0);
    add_item(SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0, '0, '0);
    add_item(SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b0, '0, '0);
    add_item(SAMPLE_MIN, SAMPLE_MAX, 1'b0, 1'b0, '0, '0);
    add_item('0, '0, 1'b0, 1'b0, '0, '0);
    add_item(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b0, '0, '0);
    // gains above their limits, unused index ignored
    add_cfg(REG_WET, '1);
    add_cfg(REG_DAMPING, 17'd32768);
    add_cfg(REG_FEEDBACK, 17'd65535);
    add_cfg(REG_TAP_DELAY_1, 17'd3);
    add_cfg(REG_TAP_DELAY_4, 17'd5);
    add_cfg(REG_UNUSED, '1);
    add_item(SAMPLE_MAX, 24'sd1, 1'b0, 1'b0, '0, '0);
    add_item(-24'sd1, SAMPLE_MIN, 1'b1, 1'b0, '0, '0);
    add_item(24'h555555, 24'hAAAAAA, 1'b0, 1'b0, '0, '0);
    add_item(24'hAAAAAA, 24'h555555, 1'b0, 1'b0, '0, '0);
    add_item(SAMPLE_MIN, SAMPLE_MIN, 1'b1, 1'b0, '0, '0);
    add_item(SAMPLE_MAX, SAMPLE_MAX, 1'b0, 1'b0, '0, '0);
    // dry again, damping beyond one
    add_cfg(REG_FEEDBACK, '0);
    add_cfg(REG_WET, '0);
    add_cfg(REG_DAMPING, '1);
    add_item(SAMPLE_MAX, SAMPLE_MIN, 1'b1, 1'b1, SAMPLE_MAX, SAMPLE_MIN);
    add_item(24'sd1, -24'sd2, 1'b0, 1'b1, 24'sd1, -24'sd2);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (plan_q[i]) begin
      row = plan_q[i];
      if (row.kind == ROW_CFG) begin
        write_reg(row.idx, row.val);
      end else begin
        send_sample(row.stim, row.pinned, row.want);
      end
    end

    n = 0;
    while (n < RANDOM_ITEMS) begin
      write_reg(REG_TAP_DELAY_1, pick_tap());
      write_reg(REG_TAP_DELAY_2, pick_tap());
      write_reg(REG_TAP_DELAY_3, pick_tap());
      write_reg(REG_TAP_DELAY_4, pick_tap());
      write_reg(REG_FEEDBACK, pick_feedback());
      write_reg(REG_WET, pick_gain());
      write_reg(REG_DAMPING, pick_gain());
      if ($urandom_range(0, 3) == 0) write_reg(REG_UNUSED, CFG_DATA_W'($urandom()));
      calm = ($urandom_range(0, 3) == 0);
      len  = $urandom_range(60, 160);
      for (k = 0; k < len && n < RANDOM_ITEMS; k++) begin
        s.left_in   = rand_sample();
        s.right_in  = rand_sample();
        s.block_end = ($urandom_range(0, 7) == 0);
        send_sample(s, 1'b0, '0);
        n++;
      end
    end

    settle_block();
    if (mismatch_count == 0) begin
      $display("stereo_multitap_feedback_reverb_unit: match");
    end else begin
      $display("stereo_multitap_feedback_reverb_unit: mismatch");
    end
    $finish;
  end

endmodule

[files.f]
rtl/smfr_pkg.sv
rtl/smfr_lane.sv
rtl/smfr_seq.sv
rtl/smfr_merge.sv
rtl/stereo_multitap_feedback_reverb_unit.sv
rtl/smfr_checker.sv
sim/tb.sv
